// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL modules; empty under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define FP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define FP_ASSERT_NEVER(lbl, expr, msg) \
  `FP_ASSERT(lbl, !(expr), msg)
`else
`define FP_ASSERT(lbl, prop, msg)
`define FP_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

// ===== rtl/core/fp4bsd_pkg.sv =====
// Types, constants and code decoders of the block-scaled FP4 dot product.
package fp4bsd_pkg;

  localparam logic [31:0] F32_CANON_NAN = 32'h7FC0_0000;
  localparam logic [31:0] F32_ONE       = 32'h3F80_0000;
  localparam logic [31:0] F32_NEG_ZERO  = 32'h8000_0000;
  localparam logic [31:0] F32_POS_ZERO  = 32'h0000_0000;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_MAC,
    SEQ_BSCALE,
    SEQ_BACC,
    SEQ_RPROD,
    SEQ_RACC,
    SEQ_EMIT
  } seq_state_e;

  typedef struct packed {
    logic        valid;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
  } fma_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] result;
  } fma_rsp_t;

  function automatic logic [31:0] dec_weight_code(input logic [3:0] code);
    logic [30:0] mag;
    case (code[2:0])
      3'd0:    mag = 31'h0000_0000;
      3'd1:    mag = 31'h3F00_0000;
      3'd2:    mag = 31'h3F80_0000;
      3'd3:    mag = 31'h3FC0_0000;
      3'd4:    mag = 31'h4000_0000;
      3'd5:    mag = 31'h4040_0000;
      3'd6:    mag = 31'h4080_0000;
      default: mag = 31'h40C0_0000;
    endcase
    return {code[3], mag};
  endfunction

  function automatic logic [31:0] dec_scale_code(input logic [7:0] code);
    logic [3:0]  e;
    logic [2:0]  m;
    logic [30:0] mag;
    e = code[6:3];
    m = code[2:0];
    if (e == 4'hF && m == 3'h7) begin
      mag = F32_CANON_NAN[30:0];
    end else if (e == 4'h0) begin
      case (m) inside
        3'd0:       mag = 31'd0;
        3'd1:       mag = {8'd118, 23'd0};
        3'd2, 3'd3: mag = {8'd119, m[0], 22'd0};
        default:    mag = {8'd120, m[1:0], 21'd0};
      endcase
    end else begin
      mag = {8'({4'd0, e} + 8'd120), m, 20'd0};
    end
    return {code[7], mag};
  endfunction

endpackage

// ===== rtl/core/fp4bsd_fma.sv =====
// Four-stage binary32 fused multiply-add with round to nearest even.
`include "assert_macros.svh"
module fp4bsd_fma (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fp4bsd_pkg::fma_req_t req_i,
  output fp4bsd_pkg::fma_rsp_t rsp_o
);

  localparam int MAG_W = 78;

  typedef struct packed {
    logic nan;
    logic inf;
    logic inf_sign;
  } spec_t;

  // stage 1: unpack, multiply, alignment amount
  logic [7:0]  a_exp, b_exp, c_exp;
  logic        a_zero, b_zero, c_zero, a_inf, b_inf, c_inf, a_nan, b_nan, c_nan;
  logic [23:0] ma, mb, mc;
  logic [11:0] ea, eb, ec, sh_raw;
  logic        sp, clamp;
  spec_t       spec1;

  logic        v1_q, v2_q, v3_q, v4_q;
  logic [47:0] s1_prod_q, s1_prod_d;
  logic [23:0] s1_mc_q;
  logic [6:0]  s1_sh_q, s1_sh_d;
  logic [11:0] s1_e0_q, s1_e0_d;
  logic        s1_sp_q, s1_sc_q;
  spec_t       s1_spec_q;

  always_comb begin
    a_exp  = req_i.a[30:23];
    b_exp  = req_i.b[30:23];
    c_exp  = req_i.c[30:23];
    a_zero = (req_i.a[30:0] == '0);
    b_zero = (req_i.b[30:0] == '0);
    c_zero = (req_i.c[30:0] == '0);
    a_inf  = (a_exp == 8'hFF) && (req_i.a[22:0] == '0);
    b_inf  = (b_exp == 8'hFF) && (req_i.b[22:0] == '0);
    c_inf  = (c_exp == 8'hFF) && (req_i.c[22:0] == '0);
    a_nan  = (a_exp == 8'hFF) && (req_i.a[22:0] != '0);
    b_nan  = (b_exp == 8'hFF) && (req_i.b[22:0] != '0);
    c_nan  = (c_exp == 8'hFF) && (req_i.c[22:0] != '0);
    ma     = {a_exp != 8'd0, req_i.a[22:0]};
    mb     = {b_exp != 8'd0, req_i.b[22:0]};
    mc     = {c_exp != 8'd0, req_i.c[22:0]};
    ea     = (a_exp == 8'd0) ? 12'd1 : {4'd0, a_exp};
    eb     = (b_exp == 8'd0) ? 12'd1 : {4'd0, b_exp};
    ec     = (c_exp == 8'd0) ? 12'd1 : {4'd0, c_exp};
    sp     = req_i.a[31] ^ req_i.b[31];
    s1_prod_d = {24'd0, ma} * {24'd0, mb};
    sh_raw = ea + eb - ec - 12'd100;
    // addend far above the product: anchor the window on the addend
    clamp  = sh_raw[11] && !c_zero;
    if (sh_raw[11]) begin
      s1_sh_d = 7'd0;
    end else if (sh_raw > 12'd100) begin
      s1_sh_d = 7'd100;
    end else begin
      s1_sh_d = sh_raw[6:0];
    end
    s1_e0_d = clamp ? (ec - 12'd202) : (ea + eb - 12'd302);
    spec1.nan = a_nan || b_nan || c_nan || (a_inf && b_zero) || (b_inf && a_zero) ||
                ((a_inf || b_inf) && c_inf && (sp != req_i.c[31]));
    spec1.inf = a_inf || b_inf || c_inf;
    spec1.inf_sign = (a_inf || b_inf) ? sp : req_i.c[31];
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid) begin
      s1_prod_q <= s1_prod_d;
      s1_mc_q   <= mc;
      s1_sh_q   <= s1_sh_d;
      s1_e0_q   <= s1_e0_d;
      s1_sp_q   <= sp;
      s1_sc_q   <= req_i.c[31];
      s1_spec_q <= spec1;
    end
  end

  // stage 2: align addend with sticky, add or subtract
  logic [MAG_W-1:0]   av, a_al, pv;
  logic [MAG_W+99:0]  a_wide;
  logic [MAG_W:0]     diff;
  logic [MAG_W-1:0]   s2_mag_q, s2_mag_d;
  logic               s2_sign_q, s2_sign_d, s2_zsign_q;
  logic [11:0]        s2_e0_q;
  spec_t              s2_spec_q;

  always_comb begin
    av     = {1'b0, s1_mc_q, 53'd0};
    a_wide = {av, 100'd0} >> s1_sh_q;
    a_al   = {a_wide[MAG_W+99:101], a_wide[100] | (|a_wide[99:0])};
    pv     = {27'd0, s1_prod_q, 3'd0};
    diff   = {1'b0, a_al} - {1'b0, pv};
    if (s1_sp_q != s1_sc_q) begin
      if (diff[MAG_W]) begin
        s2_mag_d  = pv - a_al;
        s2_sign_d = s1_sp_q;
      end else begin
        s2_mag_d  = diff[MAG_W-1:0];
        s2_sign_d = s1_sc_q;
      end
    end else begin
      s2_mag_d  = a_al + pv;
      s2_sign_d = s1_sc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      s2_mag_q   <= s2_mag_d;
      s2_sign_q  <= s2_sign_d;
      s2_zsign_q <= s1_sp_q & s1_sc_q;
      s2_e0_q    <= s1_e0_q;
      s2_spec_q  <= s1_spec_q;
    end
  end

  // stage 3: leading one, exponent, normalizing shift amount
  logic [6:0]       lead;
  logic [11:0]      er_norm, lsbpos;
  logic             normal;
  logic [MAG_W-1:0] s3_mag_q;
  logic [11:0]      s3_sa_q;
  logic [7:0]       s3_efield_q;
  logic             s3_ovf_q, s3_sign_q, s3_zero_q, s3_zsign_q;
  spec_t            s3_spec_q;

  always_comb begin
    lead = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (s2_mag_q[i]) begin
        lead = 7'(i);
      end
    end
    er_norm = s2_e0_q + {5'd0, lead} + 12'd126;
    normal  = !er_norm[11] && (er_norm != 12'd0);
    lsbpos  = normal ? ({5'd0, lead} - 12'd23) : (12'd0 - 12'd148 - s2_e0_q);
  end

  always_ff @(posedge clk_i) begin
    if (v2_q) begin
      s3_mag_q    <= s2_mag_q;
      s3_sa_q     <= 12'd54 - lsbpos;
      s3_efield_q <= normal ? 8'(er_norm - 12'd1) : 8'd0;
      s3_ovf_q    <= normal && (er_norm >= 12'd255);
      s3_sign_q   <= s2_sign_q;
      s3_zero_q   <= (s2_mag_q == '0);
      s3_zsign_q  <= s2_zsign_q;
      s3_spec_q   <= s2_spec_q;
    end
  end

  // stage 4: shift, round, pack
  logic [MAG_W-1:0]  nrm;
  logic [MAG_W+78:0] r_wide;
  logic [11:0]       rs;
  logic              st_r, guard, sticky, rup;
  logic [23:0]       mant;
  logic [30:0]       packed_mag;
  logic [31:0]       res_d, s4_res_q;

  always_comb begin
    rs     = 12'd0 - s3_sa_q;
    r_wide = '0;
    if (!s3_sa_q[11]) begin
      nrm  = s3_mag_q << s3_sa_q[6:0];
      st_r = 1'b0;
    end else begin
      if (rs > 12'd79) begin
        rs = 12'd79;
      end
      r_wide = {s3_mag_q, 79'd0} >> rs[6:0];
      nrm    = r_wide[MAG_W+78:79];
      st_r   = |r_wide[78:0];
    end
    mant   = nrm[77:54];
    guard  = nrm[53];
    sticky = (|nrm[52:0]) | st_r;
    rup    = guard & (sticky | mant[0]);
    packed_mag = {s3_efield_q, 23'd0} + {7'd0, mant} + {30'd0, rup};
    if (s3_spec_q.nan) begin
      res_d = fp4bsd_pkg::F32_CANON_NAN;
    end else if (s3_spec_q.inf) begin
      res_d = {s3_spec_q.inf_sign, 8'hFF, 23'd0};
    end else if (s3_zero_q) begin
      res_d = {s3_zsign_q, 31'd0};
    end else if (s3_ovf_q) begin
      res_d = {s3_sign_q, 8'hFF, 23'd0};
    end else begin
      res_d = {s3_sign_q, packed_mag};
    end
  end

  always_ff @(posedge clk_i) begin
    if (v3_q) begin
      s4_res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= req_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  assign rsp_o.done   = v4_q;
  assign rsp_o.result = s4_res_q;

  `FP_ASSERT(a_one_in_flight, $countones({v1_q, v2_q, v3_q, v4_q}) <= 1, "fma overlap")
  `FP_ASSERT_NEVER(a_req_busy, req_i.valid && (v1_q || v2_q || v3_q), "fma request while busy")
  `FP_ASSERT(a_nan_canon, (v4_q && s4_res_q[30:23] == 8'hFF && s4_res_q[22:0] != '0) |-> (s4_res_q == fp4bsd_pkg::F32_CANON_NAN), "non-canonical NaN")

endmodule

// ===== rtl/core/fp4_block_scaled_weighted_dot.sv =====
// Top level: element sequencer around one shared fused multiply-add unit.
// Each FMA pass is issued, runs through the 4 pipeline stages, and returns before another pass issues.
// Plain element: one MAC pass; the next transfer is accepted only once the sequencer is idle again.
// Block close adds 2 passes; segment close adds 2 more passes when the segment is routed.
// Output close: the EMIT state registers the result; input ready returns with output valid.
// Reset (rst_ni low, async) clears all sums to +0 and idles the sequencer.
`include "assert_macros.svh"
module fp4_block_scaled_weighted_dot (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  // weight_code[3:0], activation[35:4], block_scale[43:36],
  // route_weight[75:44], tensor_scale[107:76], zero pad[111:108]
  input  logic [111:0]  s_axis_tdata_i,
  // segment_valid[0], end_of_block[1], end_of_segment[2]
  input  logic [2:0]    s_axis_tuser_i,
  input  logic          s_axis_tlast_i,
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  // sum_bits[31:0]
  output logic [31:0]   m_axis_tdata_o
);

  fp4bsd_pkg::seq_state_e state_q, state_d;
  fp4bsd_pkg::fma_req_t   fma_req;
  fp4bsd_pkg::fma_rsp_t   fma_rsp;

  logic        pend_q, pend_d;
  logic [31:0] w_q, act_q, sc_q, rw_q, ts_q;
  logic        eob_q, eos_q, eoo_q, route_q;
  logic [31:0] block_q, block_d, seg_q, seg_d, tot_q, tot_d, tmp_q, tmp_d;
  logic        out_valid_q, out_valid_d;
  logic [31:0] out_data_q;
  logic        in_xfer, emit_go, issue;

  assign s_axis_tready_o = (state_q == fp4bsd_pkg::SEQ_IDLE);
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;
  assign emit_go         = (state_q == fp4bsd_pkg::SEQ_EMIT) &&
                           (!out_valid_q || m_axis_tready_i);

  fp4bsd_fma u_fma (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (fma_req),
    .rsp_o  (fma_rsp)
  );

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      w_q   <= fp4bsd_pkg::dec_weight_code(s_axis_tdata_i[3:0]);
      act_q <= s_axis_tdata_i[35:4];
      sc_q  <= fp4bsd_pkg::dec_scale_code(s_axis_tdata_i[43:36]);
      rw_q  <= s_axis_tdata_i[75:44];
      ts_q  <= s_axis_tdata_i[107:76];
    end
    tmp_q <= tmp_d;
    if (emit_go) begin
      out_data_q <= (tot_q[30:23] == 8'hFF && tot_q[22:0] != '0) ?
                    fp4bsd_pkg::F32_CANON_NAN : tot_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fp4bsd_pkg::SEQ_IDLE;
      pend_q      <= 1'b0;
      eob_q       <= 1'b0;
      eos_q       <= 1'b0;
      eoo_q       <= 1'b0;
      route_q     <= 1'b0;
      block_q     <= fp4bsd_pkg::F32_POS_ZERO;
      seg_q       <= fp4bsd_pkg::F32_POS_ZERO;
      tot_q       <= fp4bsd_pkg::F32_POS_ZERO;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pend_q      <= pend_d;
      block_q     <= block_d;
      seg_q       <= seg_d;
      tot_q       <= tot_d;
      out_valid_q <= out_valid_d;
      if (in_xfer) begin
        eoo_q   <= s_axis_tlast_i;
        eos_q   <= s_axis_tuser_i[2] | s_axis_tlast_i;
        eob_q   <= s_axis_tuser_i[1] | s_axis_tuser_i[2] | s_axis_tlast_i;
        route_q <= s_axis_tuser_i[0] && (s_axis_tdata_i[74:44] != '0);
      end
    end
  end

  always_comb begin
    state_d = state_q;
    block_d = block_q;
    seg_d   = seg_q;
    tot_d   = tot_q;
    tmp_d   = tmp_q;
    issue   = 1'b0;
    fma_req = '0;

    unique case (state_q)
      fp4bsd_pkg::SEQ_MAC: begin
        fma_req.a = w_q;
        fma_req.b = act_q;
        fma_req.c = block_q;
      end
      fp4bsd_pkg::SEQ_BSCALE: begin
        fma_req.a = block_q;
        fma_req.b = sc_q;
        fma_req.c = fp4bsd_pkg::F32_NEG_ZERO;
      end
      fp4bsd_pkg::SEQ_BACC: begin
        fma_req.a = tmp_q;
        fma_req.b = fp4bsd_pkg::F32_ONE;
        fma_req.c = seg_q;
      end
      fp4bsd_pkg::SEQ_RPROD: begin
        fma_req.a = rw_q;
        fma_req.b = ts_q;
        fma_req.c = fp4bsd_pkg::F32_NEG_ZERO;
      end
      fp4bsd_pkg::SEQ_RACC: begin
        fma_req.a = tmp_q;
        fma_req.b = seg_q;
        fma_req.c = tot_q;
      end
      default: begin
        fma_req.a = '0;
      end
    endcase

    if (state_q != fp4bsd_pkg::SEQ_IDLE && state_q != fp4bsd_pkg::SEQ_EMIT) begin
      issue = !pend_q;
    end
    fma_req.valid = issue;
    pend_d = fma_rsp.done ? 1'b0 : (issue ? 1'b1 : pend_q);

    unique case (state_q)
      fp4bsd_pkg::SEQ_IDLE: begin
        if (in_xfer) begin
          state_d = fp4bsd_pkg::SEQ_MAC;
        end
      end
      fp4bsd_pkg::SEQ_MAC: begin
        if (fma_rsp.done) begin
          block_d = fma_rsp.result;
          if (eob_q) begin
            state_d = fp4bsd_pkg::SEQ_BSCALE;
          end else begin
            state_d = fp4bsd_pkg::SEQ_IDLE;
          end
        end
      end
      fp4bsd_pkg::SEQ_BSCALE: begin
        if (fma_rsp.done) begin
          tmp_d   = fma_rsp.result;
          state_d = fp4bsd_pkg::SEQ_BACC;
        end
      end
      fp4bsd_pkg::SEQ_BACC: begin
        if (fma_rsp.done) begin
          block_d = fp4bsd_pkg::F32_POS_ZERO;
          seg_d   = fma_rsp.result;
          if (!eos_q) begin
            state_d = fp4bsd_pkg::SEQ_IDLE;
          end else if (route_q) begin
            state_d = fp4bsd_pkg::SEQ_RPROD;
          end else begin
            // skipped segment still drops its sum
            seg_d   = fp4bsd_pkg::F32_POS_ZERO;
            state_d = eoo_q ? fp4bsd_pkg::SEQ_EMIT : fp4bsd_pkg::SEQ_IDLE;
          end
        end
      end
      fp4bsd_pkg::SEQ_RPROD: begin
        if (fma_rsp.done) begin
          tmp_d   = fma_rsp.result;
          state_d = fp4bsd_pkg::SEQ_RACC;
        end
      end
      fp4bsd_pkg::SEQ_RACC: begin
        if (fma_rsp.done) begin
          tot_d   = fma_rsp.result;
          seg_d   = fp4bsd_pkg::F32_POS_ZERO;
          state_d = eoo_q ? fp4bsd_pkg::SEQ_EMIT : fp4bsd_pkg::SEQ_IDLE;
        end
      end
      fp4bsd_pkg::SEQ_EMIT: begin
        if (emit_go) begin
          tot_d   = fp4bsd_pkg::F32_POS_ZERO;
          state_d = fp4bsd_pkg::SEQ_IDLE;
        end
      end
      default: begin
        state_d = fp4bsd_pkg::SEQ_IDLE;
      end
    endcase

    if (emit_go) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  `FP_ASSERT(a_done_pend, fma_rsp.done |-> pend_q, "fma result without request")
  `FP_ASSERT_NEVER(a_issue_busy, fma_req.valid && pend_q, "fma issued while busy")
  `FP_ASSERT(a_route_gate, (state_q == fp4bsd_pkg::SEQ_RPROD) |-> (eos_q && route_q), "route pass on skipped segment")
  `FP_ASSERT(a_emit_clear, emit_go |=> (tot_q == fp4bsd_pkg::F32_POS_ZERO && m_axis_tvalid_o), "total not cleared on emit")

endmodule

// ===== bench/fp4_block_scaled_weighted_dot_tb.sv =====
// Self-checking stream testbench for the block-scaled FP4 weighted dot product.
module fp4_block_scaled_weighted_dot_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [3:0]  wcode;
    logic [31:0] act;
    logic [7:0]  bscale;
    logic [31:0] route;
    logic [31:0] tscale;
    logic        seg_valid;
    logic        eob;
    logic        eos;
    logic        eoo;
  } elem_t;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          s_axis_tvalid_i = 1'b0;
  logic          s_axis_tready_o;
  logic [111:0]  s_axis_tdata_i = '0;
  logic [2:0]    s_axis_tuser_i = '0;
  logic          s_axis_tlast_i = 1'b0;
  logic          m_axis_tvalid_o;
  logic          m_axis_tready_i = 1'b0;
  logic [31:0]   m_axis_tdata_o;

  fp4_block_scaled_weighted_dot u_dut (.*);

  always #4 clk_i = ~clk_i;

  elem_t       elem_q[$];
  logic [31:0] sum_q[$];
  logic [31:0] blk_acc, seg_acc, out_acc;
  int          err_cnt = 0;
  bit          calm = 1'b0;
  bit          in_fire = 1'b0;
  int          in_gap = 0, out_gap = 0;

  // binary32 bits to double, exact
  function automatic real f32_to_real(logic [31:0] f);
    real v;
    if (f[30:23] == 8'hFF) begin
      if (f[22:0] != 0) return $bitstoreal({f[31], 11'h7FF, 1'b1, 51'b0});
      return $bitstoreal({f[31], 11'h7FF, 52'b0});
    end
    if (f[30:23] == 8'h00) begin
      v = real'(f[22:0]) * $bitstoreal(64'h36A0_0000_0000_0000);
      return f[31] ? -v : v;
    end
    return $bitstoreal({f[31], 11'(f[30:23] + 11'd896), f[22:0], 29'b0});
  endfunction

  // double to binary32, round to nearest even
  function automatic logic [31:0] real_to_f32(real x);
    logic [63:0] d, sig, kept, rem, half;
    logic        s;
    int          e, sh;
    d = $realtobits(x);
    s = d[63];
    if (d[62:52] == 11'h7FF)
      return (d[51:0] != 0) ? {s, fp4bsd_pkg::F32_CANON_NAN[30:0]} : {s, 8'hFF, 23'b0};
    if (d[62:52] == 11'h000) return {s, 31'b0};
    e = int'(d[62:52]) - 1023;
    sig = {11'b0, 1'b1, d[51:0]};
    sh = (e >= -126) ? 29 : 29 + (-126 - e);
    if (sh > 54) return {s, 31'b0};
    kept = sig >> sh;
    rem = sig & ((64'd1 << sh) - 64'd1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && kept[0])) kept = kept + 64'd1;
    if (e >= -126) begin
      if (kept[24]) begin
        kept = kept >> 1;
        e++;
      end
      if (e > 127) return {s, 8'hFF, 23'b0};
      return {s, 8'(e + 127), kept[22:0]};
    end
    return {s, 31'(kept)};
  endfunction

  function automatic logic [31:0] f32_mul(logic [31:0] a, logic [31:0] b);
    return real_to_f32(f32_to_real(a) * f32_to_real(b));
  endfunction

  function automatic logic [31:0] f32_add(logic [31:0] a, logic [31:0] b);
    return real_to_f32(f32_to_real(a) + f32_to_real(b));
  endfunction

  // a*b + c rounded once: exact product, sum rounded to odd in double
  function automatic logic [31:0] f32_fma(logic [31:0] a, logic [31:0] b, logic [31:0] c);
    real p, cc, sm, bb, err;
    logic [63:0] u;
    p = f32_to_real(a) * f32_to_real(b);
    cc = f32_to_real(c);
    sm = p + cc;
    if (!(sm - sm == 0.0)) return real_to_f32(sm);
    bb = sm - p;
    err = (p - (sm - bb)) + (cc - bb);
    if (err != 0.0) begin
      u = $realtobits(sm);
      if (!u[0]) begin
        if ((err > 0.0) == (sm > 0.0)) u = u + 64'd1;
        else u = u - 64'd1;
        sm = $bitstoreal(u);
      end
    end
    return real_to_f32(sm);
  endfunction

  function automatic logic [31:0] fp4_weight(logic [3:0] c);
    logic [31:0] m;
    case (c[2:0])
      3'd0:    m = 32'h0000_0000;
      3'd1:    m = 32'h3F00_0000;
      3'd2:    m = 32'h3F80_0000;
      3'd3:    m = 32'h3FC0_0000;
      3'd4:    m = 32'h4000_0000;
      3'd5:    m = 32'h4040_0000;
      3'd6:    m = 32'h4080_0000;
      default: m = 32'h40C0_0000;
    endcase
    return {c[3], m[30:0]};
  endfunction

  function automatic logic [31:0] e4m3_scale(logic [7:0] c);
    logic [31:0] m;
    if (c[6:3] == 4'hF && c[2:0] == 3'h7) m = fp4bsd_pkg::F32_CANON_NAN;
    else if (c[6:3] == 4'h0) m = real_to_f32(real'(c[2:0]) / 512.0);
    else m = {1'b0, 8'(c[6:3] + 8'd120), c[2:0], 20'b0};
    return {c[7], m[30:0]};
  endfunction

  task automatic predict_dot(elem_t it);
    logic eos, eob;
    eos = it.eos | it.eoo;
    eob = it.eob | eos;
    blk_acc = f32_fma(fp4_weight(it.wcode), it.act, blk_acc);
    if (eob) begin
      seg_acc = f32_add(seg_acc, f32_mul(blk_acc, e4m3_scale(it.bscale)));
      blk_acc = fp4bsd_pkg::F32_POS_ZERO;
    end
    if (eos) begin
      if (it.seg_valid && it.route[30:0] != 0)
        out_acc = f32_fma(f32_mul(it.route, it.tscale), seg_acc, out_acc);
      seg_acc = fp4bsd_pkg::F32_POS_ZERO;
    end
    if (it.eoo) begin
      if (out_acc[30:23] == 8'hFF && out_acc[22:0] != 0)
        sum_q.push_back(fp4bsd_pkg::F32_CANON_NAN);
      else sum_q.push_back(out_acc);
      out_acc = fp4bsd_pkg::F32_POS_ZERO;
    end
  endtask

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] rand_f32();
    case ($urandom_range(0, 9))
      0:       return $urandom();
      1:       return {1'($urandom()), 8'hFF, 23'($urandom_range(0, 1) ? $urandom() : 0)};
      2:       return {1'($urandom()), 8'h00, 23'($urandom_range(0, 1) ? $urandom() : 0)};
      3:       return {1'($urandom()), 8'($urandom_range(240, 254)), 23'($urandom())};
      4:       return {1'($urandom()), 8'($urandom_range(1, 20)), 23'($urandom())};
      default: return {1'($urandom()), 8'($urandom_range(110, 140)), 23'($urandom())};
    endcase
  endfunction

  function automatic elem_t rand_elem(bit eob, bit eos, bit eoo);
    elem_t it;
    it.wcode = 4'($urandom());
    it.act = rand_f32();
    it.bscale = ($urandom_range(0, 9) == 0) ? 8'($urandom())
                                            : {1'($urandom()), 7'($urandom_range(40, 80))};
    it.route = ($urandom_range(0, 7) == 0) ? {1'($urandom()), 31'b0} : rand_f32();
    it.tscale = rand_f32();
    it.seg_valid = ($urandom_range(0, 5) != 0);
    it.eob = eob;
    it.eos = eos;
    it.eoo = eoo;
    return it;
  endfunction

  function automatic elem_t mk(logic [3:0] w, logic [31:0] a, logic [7:0] bs,
                               logic [31:0] rw, logic [31:0] ts, logic [3:0] flags);
    elem_t it;
    it.wcode = w; it.act = a; it.bscale = bs; it.route = rw; it.tscale = ts;
    {it.eoo, it.eos, it.eob, it.seg_valid} = flags;
    return it;
  endfunction

  // driver
  always @(posedge clk_i) begin
    in_fire <= s_axis_tvalid_i && s_axis_tready_o;
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      predict_dot(elem_q[0]);
      void'(elem_q.pop_front());
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid_i || in_fire)) begin
      if (in_gap > 0 || elem_q.size() == 0) begin
        s_axis_tvalid_i <= 1'b0;
        if (in_gap > 0) in_gap--;
      end else begin
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i <= {4'b0, elem_q[0].tscale, elem_q[0].route, elem_q[0].bscale,
                           elem_q[0].act, elem_q[0].wcode};
        s_axis_tuser_i <= {elem_q[0].eos, elem_q[0].eob, elem_q[0].seg_valid};
        s_axis_tlast_i <= elem_q[0].eoo;
        in_gap = pick_gap();
      end
    end
  end

  always @(negedge clk_i) begin
    if (out_gap > 0) begin
      m_axis_tready_i <= 1'b0;
      out_gap--;
    end else begin
      m_axis_tready_i <= 1'b1;
      out_gap = pick_gap();
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      if (sum_q.size() == 0) begin
        $error("sum_bits: unexpected transfer, actual %h", m_axis_tdata_o);
        err_cnt++;
      end else begin
        if (m_axis_tdata_o !== sum_q[0]) begin
          $error("sum_bits: expected %h actual %h", sum_q[0], m_axis_tdata_o);
          err_cnt++;
        end
        void'(sum_q.pop_front());
      end
    end
  end

  initial begin
    #5ms;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    int n, nblk, nseg, blen;
    blk_acc = fp4bsd_pkg::F32_POS_ZERO;
    seg_acc = fp4bsd_pkg::F32_POS_ZERO;
    out_acc = fp4bsd_pkg::F32_POS_ZERO;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: all weight codes against 1.0, scale extremes, route specials
    for (int c = 0; c < 16; c++)
      elem_q.push_back(mk(4'(c), fp4bsd_pkg::F32_ONE, 8'h38, fp4bsd_pkg::F32_ONE,
                          fp4bsd_pkg::F32_ONE,
                          (c == 7) ? 4'b0011 : (c == 15) ? 4'b1001 : 4'b0001));
    elem_q.push_back(mk(4'h7, 32'h7F7F_FFFF, 8'h7E, fp4bsd_pkg::F32_ONE,
                        fp4bsd_pkg::F32_ONE, 4'b1001));
    elem_q.push_back(mk(4'h0, 32'h7F80_0000, 8'h38, fp4bsd_pkg::F32_ONE,
                        fp4bsd_pkg::F32_ONE, 4'b1001));
    elem_q.push_back(mk(4'h2, fp4bsd_pkg::F32_ONE, 8'h7F, fp4bsd_pkg::F32_ONE,
                        fp4bsd_pkg::F32_ONE, 4'b1001));
    elem_q.push_back(mk(4'hA, fp4bsd_pkg::F32_ONE, 8'h01, fp4bsd_pkg::F32_ONE,
                        fp4bsd_pkg::F32_ONE, 4'b1001));
    elem_q.push_back(mk(4'h2, fp4bsd_pkg::F32_ONE, 8'hFF, fp4bsd_pkg::F32_NEG_ZERO,
                        fp4bsd_pkg::F32_ONE, 4'b0101));
    elem_q.push_back(mk(4'h2, fp4bsd_pkg::F32_ONE, 8'h00, fp4bsd_pkg::F32_POS_ZERO,
                        fp4bsd_pkg::F32_ONE, 4'b1101));
    elem_q.push_back(mk(4'h3, fp4bsd_pkg::F32_ONE, 8'h80, fp4bsd_pkg::F32_CANON_NAN,
                        fp4bsd_pkg::F32_ONE, 4'b1001));
    elem_q.push_back(mk(4'h5, 32'h0000_0001, 8'h38, fp4bsd_pkg::F32_ONE,
                        fp4bsd_pkg::F32_ONE, 4'b1000));
    elem_q.push_back(mk(4'hF, 32'hFFFF_FFFF, 8'hF7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'b1111));

    n = 25;
    while (n < 1450) begin
      calm = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 9) == 0) begin
        // noise with arbitrary markers
        repeat ($urandom_range(1, 8)) begin
          elem_q.push_back(rand_elem(1'($urandom()), 1'($urandom()),
                                     $urandom_range(0, 3) == 0));
          n++;
        end
      end else begin
        nseg = $urandom_range(1, 3);
        for (int s = 0; s < nseg; s++) begin
          nblk = $urandom_range(1, 3);
          for (int b = 0; b < nblk; b++) begin
            blen = ($urandom_range(0, 5) == 0) ? 16 : $urandom_range(1, 5);
            for (int e = 0; e < blen; e++) begin
              elem_q.push_back(rand_elem(e == blen - 1, e == blen - 1 && b == nblk - 1,
                                         e == blen - 1 && b == nblk - 1 && s == nseg - 1));
              n++;
            end
          end
        end
      end
      wait (elem_q.size() < 40);
    end

    wait (elem_q.size() == 0 && sum_q.size() == 0);
    repeat (200) @(posedge clk_i);
    if (err_cnt == 0 && sum_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== fp4_block_scaled_weighted_dot.f =====
+incdir+rtl/core
rtl/core/fp4bsd_pkg.sv
rtl/core/fp4bsd_fma.sv
rtl/core/fp4_block_scaled_weighted_dot.sv
bench/fp4_block_scaled_weighted_dot_tb.sv
